/* design/ist_pkg.sv */
// Shared types and constants for the integer stack with search.
// Holds the opcode, state, cell command and result types used by the cells, the control and the top level.
// No dependencies.
package ist_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = 7;
    localparam int OP_W      = 3;
    localparam int DEPTH_DEF = 64;

    // Largest count that the 7-bit count field can carry.
    localparam int CNT_MAX   = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] NO_INDEX  = {CNT_W{1'b1}};

    localparam int RES_W     = 1 + DATA_W + CNT_W + CNT_W + 1 + 1;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;         // take the neighbour nearer the top
        logic pop;          // take the neighbour nearer the bottom
        logic load_match;   // compare held entry with the key
        logic shift_match;  // move match flags one cell toward the top
    } cell_cmd_t;

    // Result item; last member sits in the lowest bits.
    typedef struct packed {
        logic                     is_full;
        logic                     is_empty;
        logic [CNT_W-1:0]         count;
        logic signed [CNT_W-1:0]  found_index;
        logic signed [DATA_W-1:0] data;
        logic                     status;
    } result_t;

endpackage

/* design/ist_cell.sv */
// One cell of the shift-register stack: holds one entry and its match flag.
// Depends on ist_pkg for widths and the cell command type.
module ist_cell
    import ist_pkg::*;
(
    input  logic                     aclk,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] upper_data,  // neighbour nearer the top
    input  logic signed [DATA_W-1:0] lower_data,  // neighbour nearer the bottom
    input  logic                     lower_match,
    output logic signed [DATA_W-1:0] data,
    output logic                     match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     match_reg;
    logic                     match_next;

    // Shift the entry down on push, up on pop, hold otherwise
    always_comb begin
        data_next = data_reg;
        if (cmd.push) begin
            data_next = upper_data;
        end else if (cmd.pop) begin
            data_next = lower_data;
        end
    end

    // Load the compare result, or pass flags toward the top during a scan
    always_comb begin
        match_next = match_reg;
        if (cmd.load_match) begin
            match_next = (data_reg == key);
        end else if (cmd.shift_match) begin
            match_next = lower_match;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* design/ist_ctrl.sv */
// Control for the integer stack: count, capacity register, search scan and result queue.
// Depends on ist_pkg; drives the cell chain through a cell_cmd_t broadcast.
module ist_ctrl
    import ist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [DATA_W-1:0] top_data,
    input  logic                     head_match,
    output cell_cmd_t                cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output result_t                  m_res
);

    localparam int               DEPTH_CLIP = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
    localparam logic [CNT_W-1:0] DEPTH_LIM  = CNT_W'(DEPTH_CLIP);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_res_reg, pend_res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;

    logic             accept;
    logic [CNT_W-1:0] cap_use;
    logic             scan_hit;
    logic             scan_miss;
    logic             res_wr;
    result_t          res_new;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign accept    = s_valid && s_ready;
    assign cap_use   = (capacity_reg < DEPTH_LIM) ? capacity_reg : DEPTH_LIM;
    assign scan_miss = (step_reg == count_reg);
    assign scan_hit  = !scan_miss && head_match;
    assign out_free  = !out_valid_reg || m_ready;

    // Next state: a search enters the scan, which ends on the first hit or past the bottom
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_SEARCH)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: cell commands, count update and the new result
    always_comb begin
        cmd                 = '0;
        count_next          = count_reg;
        step_next           = step_reg;
        res_wr              = 1'b0;
        res_new             = '0;
        res_new.found_index = NO_INDEX;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (accept) begin
                    res_wr = 1'b1;
                    unique case (s_op)
                        OP_PUSH: begin
                            if (count_reg < cap_use) begin
                                cmd.push   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                res_new.status = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (count_reg != '0) begin
                                cmd.pop      = 1'b1;
                                count_next   = count_reg - CNT_W'(1);
                                res_new.data = top_data;
                            end else begin
                                res_new.status = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (count_reg != '0) begin
                                res_new.data = top_data;
                            end else begin
                                res_new.status = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            cmd.load_match = 1'b1;
                            res_wr         = 1'b0;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            res_new.status = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    res_wr              = 1'b1;
                    res_new.found_index = count_reg - step_reg - CNT_W'(1);
                end else if (scan_miss) begin
                    res_wr = 1'b1;
                end else begin
                    cmd.shift_match = 1'b1;
                    step_next       = step_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
        res_new.count    = count_next;
        res_new.is_empty = (count_next == '0);
        res_new.is_full  = (count_next >= cap_use);
    end

    // Capacity register write
    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready) begin
            capacity_next = cfg_data;
        end
    end

    // Result queue: a pending slot parts the work from a stalled output register
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end else if (res_wr) begin
                out_valid_next = 1'b1;
                out_res_next   = res_new;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (res_wr) begin
            pend_valid_next = 1'b1;
            pend_res_next   = res_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_RESET;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_res_reg <= pend_res_next;
        out_res_reg  <= out_res_next;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_LIM)
        else $error("count beyond usable depth");

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a held output");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (step_reg <= count_reg))
        else $error("scan step past the bottom of the stack");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance the count");

    a_scan_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_ready)
        else $error("input taken during a search scan");
`endif

endmodule

/* design/integer_stack_with_search.sv */
// Top level of the integer stack with search: chain of stack cells plus control.
// Depends on ist_pkg, ist_cell and ist_ctrl.
//
//  channel | ports                            | contents
//  --------+----------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| tdata: value; tuser: opcode
//  result  | m_tvalid m_tready m_tdata        | status, data, found_index, count, flags
//  config  | cfg_valid cfg_ready cfg_data     | capacity, always ready
//
// Push, pop, peek and clear inputs may follow back to back while the result output keeps up.
// Search compares in every cell at once, then shifts the match flags toward the top
// one cell per cycle; the result is written on the first hit at the top cell or once
// the scan passes the bottom, and the next input is taken when the control is idle again.
// aresetn (synchronous) empties the stack and sets capacity to 64; entries are not cleared.
// A stalled result output holds one result and a pending slot a second; input stalls
// only when both are full or while a search scan runs.
module integer_stack_with_search
    import ist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,    // capacity
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,     // [31:0] value
    input  logic [OP_W-1:0]      s_tuser,     // [2:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // [0] status, [32:1] data, [39:33] found_index,
                                              // [46:40] count, [47] is_empty, [48] is_full
);

    cell_cmd_t                cmd;
    result_t                  m_res;
    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic                     cell_match [DEPTH];
    logic signed [DATA_W-1:0] value;

    assign value = s_tdata;

    // Build the chain; cell 0 holds the top of the stack
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [DATA_W-1:0] upper_data;
        logic signed [DATA_W-1:0] lower_data;
        logic                     lower_match;

        if (k == 0) begin : g_top
            assign upper_data = value;
        end else begin : g_mid
            assign upper_data = cell_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_bottom
            assign lower_data  = '0;
            assign lower_match = 1'b0;
        end else begin : g_inner
            assign lower_data  = cell_data[k+1];
            assign lower_match = cell_match[k+1];
        end

        ist_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .key         (value),
            .upper_data  (upper_data),
            .lower_data  (lower_data),
            .lower_match (lower_match),
            .data        (cell_data[k]),
            .match       (cell_match[k])
        );
    end

    ist_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_op       (s_tuser),
        .top_data   (cell_data[0]),
        .head_match (cell_match[0]),
        .cmd        (cmd),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    // Pack the result, zero-filled to whole bytes
    assign m_tdata = {{(M_TDATA_W - RES_W){1'b0}}, m_res};

endmodule
